FILE: sv/bmmd_pkg.sv
package bmmd_pkg;

  localparam int unsigned ADDR_BITS = 20;

  localparam logic [2:0] ACT_CPU_RD = 3'd0;
  localparam logic [2:0] ACT_CPU_WR = 3'd1;
  localparam logic [2:0] ACT_DMA_RD = 3'd2;
  localparam logic [2:0] ACT_DMA_WR = 3'd3;
  localparam logic [2:0] ACT_IO_WR  = 3'd4;
  localparam logic [2:0] ACT_IO_RD  = 3'd5;
  localparam logic [2:0] ACT_BANK   = 3'd6;

  localparam logic [2:0] REG_NONE  = 3'd0;
  localparam logic [2:0] REG_RAM   = 3'd1;
  localparam logic [2:0] REG_VRAM  = 3'd2;
  localparam logic [2:0] REG_KANJI = 3'd3;
  localparam logic [2:0] REG_DIC   = 3'd4;
  localparam logic [2:0] REG_IPL   = 3'd5;
  localparam logic [2:0] REG_EXP   = 3'd6;

  localparam logic [2:0] WIN_KANJI_LO = 3'd7;
  localparam logic [2:0] WIN_KANJI_HI = 3'd6;
  localparam logic [2:0] WIN_DIC_LO   = 3'd5;
  localparam logic [2:0] WIN_DIC_HI   = 3'd4;
  localparam logic [2:0] WIN_EXP      = 3'd3;

  localparam logic [1:0] MODEL_BASE = 2'd0;

  localparam logic [7:0] PORT_DMA_HIGH = 8'h50;
  localparam logic [7:0] PORT_EXP_BANK = 8'hcd;

  localparam logic [7:0] IO_READ_BASE  = 8'hf0;
  localparam logic [7:0] UNMAPPED_READ = 8'hff;

  localparam logic [2:0] REG_IDX_MODEL = 3'd0;

  typedef struct packed {
    logic [2:0] window_select;
    logic [3:0] expansion_bank;
    logic [3:0] dma_high_address;
  } bmmd_state_t;

  localparam bmmd_state_t STATE_RESET = '{
    window_select:    3'd7,
    expansion_bank:   4'd0,
    dma_high_address: 4'd0
  };

  typedef struct packed {
    logic [2:0]           action;
    logic [ADDR_BITS-1:0] address;
    logic [7:0]           data;
  } bmmd_item_t;

  typedef struct packed {
    logic [2:0]           region;
    logic [ADDR_BITS-1:0] offset;
    logic                 write_enable;
    logic [7:0]           read_value;
  } bmmd_result_t;

endpackage

FILE: sv/bmmd_if.sv
interface bmmd_req_if;
  import bmmd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           action;
  logic [ADDR_BITS-1:0] address;
  logic [7:0]           data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink (input valid, input action, input address, input data, output ready);
endinterface

interface bmmd_rsp_if;
  import bmmd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           region;
  logic [ADDR_BITS-1:0] offset;
  logic                 write_enable;
  logic [7:0]           read_value;

  modport source (output valid, output region, output offset, output write_enable,
                  output read_value, input ready);
  modport sink (input valid, input region, input offset, input write_enable,
                input read_value, output ready);
endinterface

FILE: sv/banked_memory_map_decoder_core.sv
// An accepted request is held in the item register, then moves to the result register once that is empty or taken.
// Throughput: one request per cycle while rsp.ready is high; decode sits between the two registers.
// Bank and port state updates apply as a request moves to the result register.
// Reset (rst, synchronous): pipeline empty, window select 7, expansion bank 0,
// DMA high address 0, machine model 0.
module banked_memory_map_decoder_core
  import bmmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bmmd_req_if.sink    req,
  bmmd_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic         [1:0] machine_model;
  bmmd_item_t   item;
  logic         item_valid;
  bmmd_state_t  state;
  bmmd_state_t  state_next;
  bmmd_result_t result_next;
  bmmd_result_t result;
  logic         result_valid;
  logic         advance;

  bmmd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .machine_model (machine_model)
  );

  bmmd_decode u_decode (
    .machine_model (machine_model),
    .item          (item),
    .state         (state),
    .result        (result_next),
    .state_next    (state_next)
  );

  assign advance   = !result_valid || rsp.ready;
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= STATE_RESET;
    end else begin
      if (req.ready) begin
        item_valid <= req.valid;
      end
      if (advance) begin
        result_valid <= item_valid;
        if (item_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.action  <= req.action;
      item.address <= req.address;
      item.data    <= req.data;
    end
    if (advance && item_valid) begin
      result <= result_next;
    end
  end

  assign rsp.valid        = result_valid;
  assign rsp.region       = result.region;
  assign rsp.offset       = result.offset;
  assign rsp.write_enable = result.write_enable;
  assign rsp.read_value   = result.read_value;

  a_we_writable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.write_enable) |->
      (result.region == REG_RAM || result.region == REG_VRAM || result.region == REG_EXP))
    else $error("write enable on a non-writable region");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.region == REG_NONE) |->
      (!result.write_enable && result.offset == '0))
    else $error("unmapped result carries offset or write enable");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && item_valid) |=> $stable(state))
    else $error("bank state changed without a request moving on");

  a_state_reset: assert property (@(posedge clk)
    rst |=> (state == STATE_RESET && !item_valid && !result_valid))
    else $error("reset did not restore state");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> req.ready)
    else $error("request stalled while result register empty");

endmodule

FILE: sv/bmmd_cfg.sv
module bmmd_cfg
  import bmmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [1:0]  machine_model
);

  logic model_sel;

  assign pready    = 1'b1;
  assign model_sel = (paddr[2] == REG_IDX_MODEL[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_model <= MODEL_BASE;
    end else if (psel && penable && pwrite && model_sel) begin
      machine_model <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (model_sel) begin
      prdata[1:0] = machine_model;
    end
  end

endmodule

FILE: sv/bmmd_decode.sv
module bmmd_decode
  import bmmd_pkg::*;
(
  input  logic [1:0]   machine_model,
  input  bmmd_item_t   item,
  input  bmmd_state_t  state,
  output bmmd_result_t result,
  output bmmd_state_t  state_next
);

  logic                 has_exp;
  logic                 large_ipl;
  logic [ADDR_BITS-1:0] a;
  logic [2:0]           map_region;
  logic [ADDR_BITS-1:0] map_offset;
  logic                 is_write;

  assign has_exp   = (machine_model != MODEL_BASE);
  assign large_ipl = machine_model[1];
  assign is_write  = item.action[0];
  assign a = item.action[1] ? {state.dma_high_address, item.address[15:0]} : item.address;

  always_comb begin
    map_region = REG_NONE;
    map_offset = '0;
    if (!a[19] || (has_exp && a[19:17] == 3'b100)) begin
      map_region = REG_RAM;
      map_offset = a;
    end else if (a[19:17] == 3'b101) begin
      unique case (state.window_select)
        WIN_KANJI_LO: begin
          map_region = REG_KANJI;
          map_offset = {3'b000, a[16:0]};
        end
        WIN_KANJI_HI: begin
          map_region = REG_KANJI;
          map_offset = {3'b001, a[16:0]};
        end
        WIN_DIC_LO: begin
          map_region = REG_DIC;
          map_offset = {3'b000, a[16:0]};
        end
        WIN_DIC_HI: begin
          map_region = REG_DIC;
          map_offset = {3'b001, a[16:0]};
        end
        WIN_EXP: begin
          if (has_exp) begin
            map_region = REG_EXP;
            map_offset = {state.expansion_bank[3:1], a[16:0]};
          end
        end
        default: begin
          map_region = REG_NONE;
        end
      endcase
    end else if (a[19:18] == 2'b11 && a[17:16] != 2'b11) begin
      map_region = REG_VRAM;
      map_offset = {2'b00, a[17:0]};
    end else if (large_ipl && a[19:15] == 5'b11111) begin
      map_region = REG_IPL;
      map_offset = {5'b00000, a[14:0]};
    end else if (a[19:14] == 6'b111111) begin
      map_region = REG_IPL;
      map_offset = {6'b000000, a[13:0]};
    end
  end

  always_comb begin
    result     = '0;
    state_next = state;
    unique case (item.action)
      ACT_CPU_RD, ACT_CPU_WR, ACT_DMA_RD, ACT_DMA_WR: begin
        if (is_write) begin
          if (map_region == REG_RAM || map_region == REG_VRAM || map_region == REG_EXP) begin
            result.region       = map_region;
            result.offset       = map_offset;
            result.write_enable = 1'b1;
          end
        end else if (map_region == REG_NONE) begin
          result.read_value = UNMAPPED_READ;
        end else begin
          result.region = map_region;
          result.offset = map_offset;
        end
      end
      ACT_IO_WR: begin
        if (item.address[7:0] == PORT_DMA_HIGH) begin
          state_next.dma_high_address = item.data[7:4];
        end else if (item.address[7:0] == PORT_EXP_BANK && has_exp) begin
          state_next.expansion_bank = item.data[3:0];
        end
      end
      ACT_IO_RD: begin
        result.read_value = IO_READ_BASE | {4'h0, state.expansion_bank};
      end
      ACT_BANK: begin
        state_next.window_select = item.data[7:5];
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

FILE: bench/tb_banked_memory_map_decoder_core.sv
module tb_banked_memory_map_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bmmd_pkg::*;

  localparam int unsigned CLK_PERIOD = 20;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [2:0] ACT_NONE = 3'd7;
  localparam logic [1:0] MODEL_EXP = 2'd1;
  localparam logic [1:0] MODEL_IPL = 2'd2;
  localparam logic [1:0] MODEL_THREE = 2'd3;
  localparam logic [2:0] MODEL_ADDR = 3'(4 * REG_IDX_MODEL);

  localparam int unsigned NUM_BOUNDARIES = 13;
  localparam logic [ADDR_BITS-1:0] BOUNDARY_ADDRS [NUM_BOUNDARIES] = '{
    20'h00000, 20'h7ffff, 20'h80000, 20'h9ffff, 20'ha0000, 20'hbffff, 20'hc0000,
    20'heffff, 20'hf0000, 20'hf7fff, 20'hf8000, 20'hfc000, 20'hfffff
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bmmd_req_if req_bus ();
  bmmd_rsp_if rsp_bus ();

  banked_memory_map_decoder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  bmmd_result_t expected_results [$];
  bmmd_state_t bank_state = STATE_RESET;
  logic [1:0] model_cfg = MODEL_BASE;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void map_bus_address(input logic [ADDR_BITS-1:0] a,
                                          output logic [2:0] region,
                                          output logic [ADDR_BITS-1:0] offset);
    logic has_exp;
    logic [ADDR_BITS-1:0] ipl_base;
    logic [ADDR_BITS-1:0] win_ofs;
    has_exp = model_cfg != MODEL_BASE;
    ipl_base = model_cfg[1] ? 20'hf8000 : 20'hfc000;
    win_ofs = a - 20'ha0000;
    region = REG_NONE;
    offset = '0;
    if (a < 20'h80000 || (has_exp && a < 20'ha0000)) begin
      region = REG_RAM;
      offset = a;
    end else if (a >= 20'ha0000 && a < 20'hc0000) begin
      case (bank_state.window_select)
        WIN_KANJI_LO: begin
          region = REG_KANJI;
          offset = win_ofs;
        end
        WIN_KANJI_HI: begin
          region = REG_KANJI;
          offset = win_ofs + 20'h20000;
        end
        WIN_DIC_LO: begin
          region = REG_DIC;
          offset = win_ofs;
        end
        WIN_DIC_HI: begin
          region = REG_DIC;
          offset = win_ofs + 20'h20000;
        end
        WIN_EXP: begin
          if (has_exp) begin
            region = REG_EXP;
            offset = {bank_state.expansion_bank[3:1], 17'd0} + win_ofs;
          end
        end
        default: ;
      endcase
    end else if (a >= 20'hc0000 && a < 20'hf0000) begin
      region = REG_VRAM;
      offset = a - 20'hc0000;
    end else if (a >= ipl_base) begin
      region = REG_IPL;
      offset = a - ipl_base;
    end
  endfunction

  function automatic bmmd_result_t decode_access(input bmmd_item_t it);
    bmmd_result_t res;
    logic [ADDR_BITS-1:0] a;
    logic [2:0] region;
    logic [ADDR_BITS-1:0] offset;
    res = '0;
    case (it.action)
      ACT_CPU_RD, ACT_CPU_WR, ACT_DMA_RD, ACT_DMA_WR: begin
        if (it.action == ACT_DMA_RD || it.action == ACT_DMA_WR)
          a = {bank_state.dma_high_address, it.address[15:0]};
        else
          a = it.address;
        map_bus_address(a, region, offset);
        if (it.action == ACT_CPU_WR || it.action == ACT_DMA_WR) begin
          if (region == REG_RAM || region == REG_VRAM || region == REG_EXP) begin
            res.region = region;
            res.offset = offset;
            res.write_enable = 1'b1;
          end
        end else if (region == REG_NONE) begin
          res.read_value = UNMAPPED_READ;
        end else begin
          res.region = region;
          res.offset = offset;
        end
      end
      ACT_IO_WR: begin
        if (it.address[7:0] == PORT_DMA_HIGH)
          bank_state.dma_high_address = it.data[7:4];
        else if (it.address[7:0] == PORT_EXP_BANK && model_cfg != MODEL_BASE)
          bank_state.expansion_bank = it.data[3:0];
      end
      ACT_IO_RD: res.read_value = IO_READ_BASE | {4'h0, bank_state.expansion_bank};
      ACT_BANK: bank_state.window_select = it.data[7:5];
      default: ;
    endcase
    return res;
  endfunction

  function automatic bmmd_item_t random_item();
    bmmd_item_t it;
    int unsigned pick;
    it.action = ACT_NONE;
    it.address = 20'($urandom);
    it.data = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 64) begin
      case (pick % 4)
        0: it.action = ACT_CPU_RD;
        1: it.action = ACT_CPU_WR;
        2: it.action = ACT_DMA_RD;
        default: it.action = ACT_DMA_WR;
      endcase
      if ($urandom_range(0, 3) == 0)
        it.address = BOUNDARY_ADDRS[$urandom_range(0, NUM_BOUNDARIES - 1)];
    end else if (pick < 78) begin
      it.action = ACT_IO_WR;
      case ($urandom_range(0, 2))
        0: it.address[7:0] = PORT_DMA_HIGH;
        1: it.address[7:0] = PORT_EXP_BANK;
        default: ;
      endcase
    end else if (pick < 86) begin
      it.action = ACT_IO_RD;
    end else if (pick < 98) begin
      it.action = ACT_BANK;
    end
    return it;
  endfunction

  always @(posedge clk) begin : scoreboard
    bmmd_result_t got;
    bmmd_result_t want;
    bmmd_item_t seen;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.region = rsp_bus.region;
        got.offset = rsp_bus.offset;
        got.write_enable = rsp_bus.write_enable;
        got.read_value = rsp_bus.read_value;
        if (expected_results.size() == 0) begin
          $error("result with no request pending: region %0d offset %h", got.region,
                 got.offset);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.region !== want.region) begin
            $error("region: expected %0d, got %0d", want.region, got.region);
            fail_count++;
          end
          if (got.offset !== want.offset) begin
            $error("offset: expected %h, got %h", want.offset, got.offset);
            fail_count++;
          end
          if (got.write_enable !== want.write_enable) begin
            $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
            fail_count++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            fail_count++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        seen.action = req_bus.action;
        seen.address = req_bus.address;
        seen.data = req_bus.data;
        expected_results.push_back(decode_access(seen));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [2:0] action, input logic [ADDR_BITS-1:0] address,
                              input logic [7:0] data);
    int unsigned gap;
    req_bus.valid <= 1'b1;
    req_bus.action <= action;
    req_bus.address <= address;
    req_bus.data <= data;
    do @(posedge clk); while (!req_bus.ready);
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_pipeline();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_model(input logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODEL_ADDR;
    pwdata <= {30'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_cfg = value;
  endtask

  task automatic test_base_map();
    send_request(ACT_CPU_RD, 20'h00000, 8'h00);
    send_request(ACT_CPU_WR, 20'h7ffff, 8'hff);
    send_request(ACT_CPU_RD, 20'h80000, 8'h00);
    send_request(ACT_CPU_RD, 20'ha0000, 8'h00);
    send_request(ACT_CPU_WR, 20'hbffff, 8'h5a);
    send_request(ACT_CPU_RD, 20'hc0000, 8'h00);
    send_request(ACT_CPU_WR, 20'heffff, 8'ha5);
    send_request(ACT_CPU_RD, 20'hf0000, 8'h00);
    send_request(ACT_CPU_RD, 20'hfbfff, 8'h00);
    send_request(ACT_CPU_RD, 20'hfc000, 8'h00);
    send_request(ACT_CPU_WR, 20'hfffff, 8'hff);
    send_request(ACT_BANK, 20'h00000, 8'hc0);
    send_request(ACT_CPU_RD, 20'hbffff, 8'h00);
    send_request(ACT_BANK, 20'hfffff, 8'ha0);
    send_request(ACT_CPU_RD, 20'ha1234, 8'h00);
    send_request(ACT_BANK, 20'h00000, 8'h80);
    send_request(ACT_CPU_RD, 20'hb0001, 8'h00);
    send_request(ACT_BANK, 20'h00000, 8'h60);
    send_request(ACT_CPU_RD, 20'ha0000, 8'h00);
    send_request(ACT_BANK, 20'h00000, 8'h1f);
    send_request(ACT_CPU_WR, 20'ha0000, 8'h11);
    send_request(ACT_IO_WR, 20'hfffcd, 8'hff);
    send_request(ACT_IO_RD, 20'hfffff, 8'h00);
    send_request(ACT_IO_WR, 20'h00050, 8'hf0);
    send_request(ACT_DMA_RD, 20'h0ffff, 8'h00);
    send_request(ACT_DMA_WR, 20'hf0000, 8'h3c);
    send_request(ACT_IO_WR, 20'h00050, 8'h0f);
    send_request(ACT_DMA_WR, 20'hf1234, 8'hc3);
    send_request(ACT_NONE, 20'hfffff, 8'hff);
    send_request(ACT_BANK, 20'h00000, 8'he0);
    settle_pipeline();
  endtask

  task automatic test_expansion_map();
    write_model(MODEL_EXP);
    send_request(ACT_CPU_RD, 20'h9ffff, 8'h00);
    send_request(ACT_CPU_WR, 20'h80000, 8'h77);
    send_request(ACT_IO_WR, 20'h000cd, 8'h0e);
    send_request(ACT_IO_RD, 20'h00000, 8'h00);
    send_request(ACT_BANK, 20'h00000, 8'h60);
    send_request(ACT_CPU_WR, 20'hbffff, 8'h99);
    send_request(ACT_CPU_RD, 20'ha0000, 8'h00);
    send_request(ACT_IO_WR, 20'h000cd, 8'hf1);
    send_request(ACT_CPU_RD, 20'ha0010, 8'h00);
    send_request(ACT_CPU_RD, 20'hf8000, 8'h00);
    settle_pipeline();
    write_model(MODEL_THREE);
    send_request(ACT_CPU_RD, 20'hf8000, 8'h00);
    send_request(ACT_CPU_WR, 20'hf7fff, 8'h12);
    send_request(ACT_CPU_RD, 20'hf7fff, 8'h00);
    send_request(ACT_IO_WR, 20'h000cd, 8'h05);
    send_request(ACT_IO_RD, 20'h000cd, 8'h00);
    send_request(ACT_CPU_RD, 20'ha0000, 8'h00);
    send_request(ACT_BANK, 20'h00000, 8'he0);
    settle_pipeline();
  endtask

  task automatic test_output_backpressure();
    bmmd_item_t it;
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (24) begin
      it = random_item();
      send_request(it.action, it.address, it.data);
    end
    settle_pipeline();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input logic [1:0] model, input int unsigned count);
    bmmd_item_t it;
    write_model(model);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) idle_on = $urandom_range(0, 3) != 0;
      it = random_item();
      send_request(it.action, it.address, it.data);
    end
    settle_pipeline();
    idle_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.action <= ACT_CPU_RD;
    req_bus.address <= '0;
    req_bus.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_base_map();
    test_expansion_map();
    test_output_backpressure();
    test_random_traffic(MODEL_IPL, 125);
    test_random_traffic(MODEL_BASE, 125);
    test_random_traffic(MODEL_THREE, 125);
    test_random_traffic(MODEL_EXP, 125);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
